[sv/hvn_pkg.sv]
// Shared types, constants and step tables for the height-map vertex normal block.
package hvn_pkg;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_COORD_BITS = 24;
   localparam int GRID_MAX_ROWS  = 128;
   localparam int GRID_REG_W     = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int NORMAL_W       = 16;
   localparam int VERTEX_IDX_W   = 7;
   localparam int STEP_W         = 6;

   // Step counts of the shared multiplier, square root and divider sequences.
   localparam logic [STEP_W-1:0] CROSS_STEPS = 6'd6;
   localparam logic [STEP_W-1:0] SQ_STEPS    = 6'd3;
   localparam logic [STEP_W-1:0] SQRT_LAST   = 6'd31;
   localparam logic [STEP_W-1:0] DIV_LAST    = 6'd15;
   localparam logic [1:0]        COMP_LAST   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CROSS,
      ST_FACE,
      ST_NLOAD,
      ST_NSHIFT,
      ST_NSQ,
      ST_NSQRT,
      ST_NDIV,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_AY_BZ,
      MUL_AZ_BY,
      MUL_AZ_BX,
      MUL_AX_BZ,
      MUL_AX_BY,
      MUL_AY_BX,
      MUL_SQ_X,
      MUL_SQ_Y,
      MUL_SQ_Z
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACC_NONE,
      ACC_CX_SET,
      ACC_CX_SUB,
      ACC_CY_SET,
      ACC_CY_SUB,
      ACC_CZ_SET,
      ACC_CZ_SUB,
      ACC_SS_SET,
      ACC_SS_ADD
   } acc_op_type;

   typedef struct packed {
      logic        accept;
      logic        diff;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        face;
      logic        nload;
      logic        nsel;
      logic        shift;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        div_init;
      logic        div_step;
      logic        div_last;
      logic [1:0]  comp;
      logic        out_load;
      logic        out_second;
   } cmd_type;

   typedef struct packed {
      logic row_zero;
      logic two;
      logic zero;
      logic high;
   } status_type;

   // Cross product: cx = ay*bz - az*by, cy = az*bx - ax*bz, cz = ax*by - ay*bx.
   function automatic mul_sel_type cross_mul(input logic [STEP_W-1:0] step);
      mul_sel_type sel;
      case (step)
         6'd0:    sel = MUL_AY_BZ;
         6'd1:    sel = MUL_AZ_BY;
         6'd2:    sel = MUL_AZ_BX;
         6'd3:    sel = MUL_AX_BZ;
         6'd4:    sel = MUL_AX_BY;
         default: sel = MUL_AY_BX;
      endcase
      return sel;
   endfunction

   // The product of a step is accumulated from prod_ff in the step after it.
   function automatic acc_op_type cross_acc(input logic [STEP_W-1:0] step);
      acc_op_type op;
      case (step)
         6'd1:    op = ACC_CX_SET;
         6'd2:    op = ACC_CX_SUB;
         6'd3:    op = ACC_CY_SET;
         6'd4:    op = ACC_CY_SUB;
         6'd5:    op = ACC_CZ_SET;
         6'd6:    op = ACC_CZ_SUB;
         default: op = ACC_NONE;
      endcase
      return op;
   endfunction

endpackage

[sv/hvn_ctrl.sv]
// Sequencer that steps the datapath through face, square-root and divide phases.
module hvn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  hvn_pkg::status_type status,
   output hvn_pkg::cmd_type    cmd
);
   import hvn_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        comp_ff, comp_in;
   logic              second_ff, second_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      comp_in   = comp_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.comp  = comp_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               // Vertices of the first row only fill the line buffer.
               if (!status.row_zero) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = '0;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            if (cnt_ff < CROSS_STEPS) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = cross_mul(cnt_ff);
            end
            cmd.acc_op = cross_acc(cnt_ff);
            if (cnt_ff == CROSS_STEPS) begin
               state_in = ST_FACE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_FACE: begin
            cmd.face  = 1'b1;
            second_in = 1'b0;
            state_in  = ST_NLOAD;
         end
         ST_NLOAD: begin
            cmd.nload = 1'b1;
            cmd.nsel  = second_ff;
            state_in  = ST_NSHIFT;
         end
         ST_NSHIFT: begin
            if (status.zero) begin
               state_in = ST_OUT;
            end else if (status.high) begin
               cmd.shift = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = ST_NSQ;
            end
         end
         ST_NSQ: begin
            if (cnt_ff < SQ_STEPS) begin
               cmd.mul_en = 1'b1;
               case (cnt_ff)
                  6'd0:    cmd.mul_sel = MUL_SQ_X;
                  6'd1:    cmd.mul_sel = MUL_SQ_Y;
                  default: cmd.mul_sel = MUL_SQ_Z;
               endcase
            end
            cmd.sqrt_init = (cnt_ff == 6'd0);
            if (cnt_ff == 6'd1) begin
               cmd.acc_op = ACC_SS_SET;
            end else if (cnt_ff != 6'd0) begin
               cmd.acc_op = ACC_SS_ADD;
            end
            if (cnt_ff == SQ_STEPS) begin
               cnt_in   = '0;
               state_in = ST_NSQRT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_NSQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = ST_NDIV;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_NDIV: begin
            cmd.div_init = (cnt_ff == 6'd0);
            cmd.div_step = (cnt_ff != 6'd0);
            cmd.div_last = (cnt_ff == DIV_LAST);
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               if (comp_ff == COMP_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load   = 1'b1;
               cmd.out_second = second_ff;
               if (status.two && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = ST_NLOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/hvn_dpath.sv]
// Datapath: line buffers, shared multiplier, face sums, square root, divider, result register.
module hvn_dpath #(
   parameter int MAX_WIDTH  = hvn_pkg::DEF_MAX_WIDTH,
   parameter int COORD_BITS = hvn_pkg::DEF_COORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [hvn_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [hvn_pkg::GRID_REG_W-1:0]           csr_wdata,
   input  logic signed [COORD_BITS-1:0]             req_pos_x,
   input  logic signed [COORD_BITS-1:0]             req_pos_y,
   input  logic signed [COORD_BITS-1:0]             req_pos_z,
   input  hvn_pkg::cmd_type                         cmd,
   output hvn_pkg::status_type                      status,
   output logic signed [hvn_pkg::NORMAL_W-1:0]      rsp_normal_x,
   output logic signed [hvn_pkg::NORMAL_W-1:0]      rsp_normal_y,
   output logic signed [hvn_pkg::NORMAL_W-1:0]      rsp_normal_z,
   output logic [hvn_pkg::VERTEX_IDX_W-1:0]         rsp_vertex_col,
   output logic [hvn_pkg::VERTEX_IDX_W-1:0]         rsp_vertex_row,
   output logic                                     rsp_degenerate,
   output logic                                     rsp_run_last
);
   import hvn_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CB     = COORD_BITS;
   localparam int DIF_W  = CB + 1;
   localparam int FACE_W = (2 * CB + 3 > 64) ? 64 : 2 * CB + 3;
   localparam int SUM_W  = (FACE_W + 2 > 64) ? 64 : FACE_W + 2;
   localparam int MAG_W  = (SUM_W > 32) ? SUM_W : 32;
   localparam int MUL_W  = (DIF_W > 32) ? DIF_W : 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WCAP   = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
   localparam int REM_W  = 47;

   // Grid size and position of the next vertex.
   logic [GRID_REG_W-1:0]   gw_ff, gh_ff;
   logic [GRID_REG_W-1:0]   col_ff;
   logic [VERTEX_IDX_W-1:0] row_ff;
   logic [GRID_REG_W-1:0]   w_eff, h_eff;
   logic [GRID_REG_W:0]     col_inc;
   logic [GRID_REG_W:0]     row_inc;

   always_comb begin
      if (gw_ff < 8'd2) begin
         w_eff = 8'd2;
      end else if (gw_ff > 8'(WCAP)) begin
         w_eff = 8'(WCAP);
      end else begin
         w_eff = gw_ff;
      end
      if (gh_ff < 8'd2) begin
         h_eff = 8'd2;
      end else if (gh_ff > 8'(GRID_MAX_ROWS)) begin
         h_eff = 8'(GRID_MAX_ROWS);
      end else begin
         h_eff = gh_ff;
      end
      col_inc = {1'b0, col_ff} + 9'd1;
      row_inc = {2'b00, row_ff} + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff  <= 8'(GRID_MAX_ROWS);
         gh_ff  <= 8'(GRID_MAX_ROWS);
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            gw_ff  <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
         end else if (csr_index == CSR_GRID_HEIGHT) begin
            gh_ff  <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
         end
      end else if (cmd.accept) begin
         if (col_inc >= {1'b0, w_eff}) begin
            col_ff <= '0;
            row_ff <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[VERTEX_IDX_W-1:0];
         end else begin
            col_ff <= col_inc[GRID_REG_W-1:0];
         end
      end
   end

   // Item being worked on.
   logic [GRID_REG_W-1:0]   c_ff;
   logic [VERTEX_IDX_W-1:0] r_ff;
   logic                    has_cur_ff, has_left_ff, two_ff, r_ge2_ff;
   logic [3*CB-1:0]         v_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         c_ff        <= col_ff;
         r_ff        <= row_ff;
         has_cur_ff  <= col_inc < {1'b0, w_eff};
         has_left_ff <= col_ff != '0;
         two_ff      <= row_inc == {1'b0, h_eff};
         r_ge2_ff    <= row_ff >= 7'd2;
         v_ff        <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   // Line buffers.
   logic [3*CB-1:0]     row_mem  [MAX_WIDTH];
   logic [3*FACE_W-1:0] face_mem [MAX_WIDTH];
   logic [3*CB-1:0]     rb0_ff, rb1_ff;
   logic [3*FACE_W-1:0] fu_ff;
   logic [ADDR_W-1:0]   rd_addr0, rd_addr1;
   logic [FACE_W-1:0]   cur_ff  [3];
   logic [FACE_W-1:0]   left_ff [3];
   logic [FACE_W-1:0]   ul_ff   [3];

   assign rd_addr0 = ADDR_W'(col_ff);
   assign rd_addr1 = ADDR_W'(col_inc);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rb0_ff            <= row_mem[rd_addr0];
         rb1_ff            <= row_mem[rd_addr1];
         row_mem[rd_addr0] <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fu_ff <= face_mem[rd_addr0];
      end
      if (cmd.face && has_cur_ff) begin
         face_mem[ADDR_W'(c_ff)] <= {cur_ff[2], cur_ff[1], cur_ff[0]};
      end
   end

   // Edge vectors a = upper - v, b = v - upper right.
   logic [DIF_W-1:0] dif_a_ff [3];
   logic [DIF_W-1:0] dif_b_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         for (int k = 0; k < 3; k++) begin
            dif_a_ff[k] <= {rb0_ff[k*CB+CB-1], rb0_ff[k*CB +: CB]}
                         - {v_ff[k*CB+CB-1], v_ff[k*CB +: CB]};
            dif_b_ff[k] <= {v_ff[k*CB+CB-1], v_ff[k*CB +: CB]}
                         - {rb1_ff[k*CB+CB-1], rb1_ff[k*CB +: CB]};
         end
      end
   end

   // Shared multiplier.
   logic [MAG_W-1:0]          mag_ff [3];
   logic                      neg_ff [3];
   logic signed [MUL_W-1:0]   op1, op2;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [63:0]               sq_v_ff, sq_r_ff, sq_bit_ff;

   function automatic logic signed [MUL_W-1:0] sx(input logic [DIF_W-1:0] d);
      return MUL_W'($signed(d));
   endfunction

   function automatic logic signed [MUL_W-1:0] zx(input logic [MAG_W-1:0] m);
      return MUL_W'({1'b0, m[30:0]});
   endfunction

   always_comb begin
      case (cmd.mul_sel)
         MUL_AY_BZ: begin op1 = sx(dif_a_ff[1]); op2 = sx(dif_b_ff[2]); end
         MUL_AZ_BY: begin op1 = sx(dif_a_ff[2]); op2 = sx(dif_b_ff[1]); end
         MUL_AZ_BX: begin op1 = sx(dif_a_ff[2]); op2 = sx(dif_b_ff[0]); end
         MUL_AX_BZ: begin op1 = sx(dif_a_ff[0]); op2 = sx(dif_b_ff[2]); end
         MUL_AX_BY: begin op1 = sx(dif_a_ff[0]); op2 = sx(dif_b_ff[1]); end
         MUL_AY_BX: begin op1 = sx(dif_a_ff[1]); op2 = sx(dif_b_ff[0]); end
         MUL_SQ_X:  begin op1 = zx(mag_ff[0]);   op2 = zx(mag_ff[0]);   end
         MUL_SQ_Y:  begin op1 = zx(mag_ff[1]);   op2 = zx(mag_ff[1]);   end
         MUL_SQ_Z:  begin op1 = zx(mag_ff[2]);   op2 = zx(mag_ff[2]);   end
         default:   begin op1 = '0;              op2 = '0;              end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= op1 * op2;
      end
   end

   // Face and sum-of-squares accumulation.
   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_CX_SET: cur_ff[0] <= FACE_W'(prod_ff);
         ACC_CX_SUB: cur_ff[0] <= cur_ff[0] - FACE_W'(prod_ff);
         ACC_CY_SET: cur_ff[1] <= FACE_W'(prod_ff);
         ACC_CY_SUB: cur_ff[1] <= cur_ff[1] - FACE_W'(prod_ff);
         ACC_CZ_SET: cur_ff[2] <= FACE_W'(prod_ff);
         ACC_CZ_SUB: cur_ff[2] <= cur_ff[2] - FACE_W'(prod_ff);
         default: ;
      endcase
   end

   // Face sums: four faces around the vertex above, two around the vertex itself.
   logic [SUM_W-1:0] sum1 [3];
   logic [SUM_W-1:0] sum2 [3];
   logic [SUM_W-1:0] sum1_ff [3];
   logic [SUM_W-1:0] sum2_ff [3];

   function automatic logic [SUM_W-1:0] fx(input logic [FACE_W-1:0] f, input logic en);
      return en ? SUM_W'($signed(f)) : '0;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum2[k] = fx(left_ff[k], has_left_ff) + fx(cur_ff[k], has_cur_ff);
         sum1[k] = sum2[k] + fx(ul_ff[k], has_left_ff && r_ge2_ff)
                 + fx(fu_ff[k*FACE_W +: FACE_W], has_cur_ff && r_ge2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            left_ff[k] <= '0;
            ul_ff[k]   <= '0;
         end
      end else if (cmd.face && has_cur_ff) begin
         for (int k = 0; k < 3; k++) begin
            left_ff[k] <= cur_ff[k];
            ul_ff[k]   <= fu_ff[k*FACE_W +: FACE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.face) begin
         sum1_ff <= sum1;
         sum2_ff <= sum2;
      end
   end

   // Normalization: sign and magnitude, right shift until below 2^31.
   logic             zero_ff;
   logic [SUM_W-1:0] src [3];
   logic [SUM_W-1:0] abs_v [3];
   logic             high;

   always_comb begin
      high = 1'b0;
      for (int k = 0; k < 3; k++) begin
         src[k]   = cmd.nsel ? sum2_ff[k] : sum1_ff[k];
         abs_v[k] = src[k][SUM_W-1] ? (~src[k] + 1'b1) : src[k];
         high     = high | (|mag_ff[k][MAG_W-1:31]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nload) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= src[k][SUM_W-1];
            mag_ff[k] <= MAG_W'(abs_v[k]);
         end
         zero_ff <= (src[0] == '0) && (src[1] == '0) && (src[2] == '0);
      end else if (cmd.shift) begin
         for (int k = 0; k < 3; k++) begin
            mag_ff[k] <= mag_ff[k] >> 1;
         end
      end
   end

   // Bit-pair square root of the sum of squares.
   logic [63:0] sq_trial;
   assign sq_trial = sq_r_ff + sq_bit_ff;

   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_SS_SET: sq_v_ff <= prod_ff[63:0];
         ACC_SS_ADD: sq_v_ff <= sq_v_ff + prod_ff[63:0];
         default: begin
            if (cmd.sqrt_step && (sq_v_ff >= sq_trial)) begin
               sq_v_ff <= sq_v_ff - sq_trial;
            end
         end
      endcase
      if (cmd.sqrt_init) begin
         sq_r_ff   <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         sq_r_ff   <= (sq_v_ff >= sq_trial) ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   // Restoring divider: q = (mag * 2^14 + len/2) / len, one quotient bit per step.
   logic [31:0]          len;
   logic [REM_W-1:0]     rem_ff, dvs_ff;
   logic [14:0]          q_ff, q_next;
   logic                 q_bit;
   logic [NORMAL_W-1:0]  nrm_ff [3];

   assign len    = (sq_r_ff[31:0] == '0) ? 32'd1 : sq_r_ff[31:0];
   assign q_bit  = rem_ff >= dvs_ff;
   assign q_next = {q_ff[13:0], q_bit};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= REM_W'({mag_ff[cmd.comp][30:0], 14'd0}) + REM_W'(len >> 1);
         dvs_ff <= REM_W'({len, 14'd0});
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_ff - dvs_ff : rem_ff;
         dvs_ff <= dvs_ff >> 1;
         q_ff   <= q_next;
         if (cmd.div_last) begin
            nrm_ff[cmd.comp] <= neg_ff[cmd.comp] ? NORMAL_W'(~{1'b0, q_next} + 16'd1)
                                                 : NORMAL_W'({1'b0, q_next});
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_normal_x   <= zero_ff ? '0 : nrm_ff[0];
         rsp_normal_y   <= zero_ff ? '0 : nrm_ff[1];
         rsp_normal_z   <= zero_ff ? '0 : nrm_ff[2];
         rsp_vertex_col <= c_ff[VERTEX_IDX_W-1:0];
         rsp_vertex_row <= cmd.out_second ? r_ff : r_ff - 7'd1;
         rsp_degenerate <= zero_ff;
         rsp_run_last   <= cmd.out_second || !two_ff;
      end
   end

   assign status.row_zero = (row_ff == '0);
   assign status.two      = two_ff;
   assign status.zero     = zero_ff;
   assign status.high     = high;

endmodule

[sv/heightmap_vertex_normals.sv]
// Top level of the averaged vertex normal unit for height-map grids.
//
// Vertices enter in raster order on the req_ channel, one beat per vertex, as
// signed Q16.8 positions. A beat is taken when req_valid is high and req_stall
// is low. Normals leave on the rsp_ channel as Q1.14 unit vectors with the
// vertex column and row. The normals of row j leave while row j+1 arrives; on
// the last row each input beat yields two result beats, the second one for
// the arriving vertex itself, and run_last marks the last beat of an input.
// One vertex is processed at a time. A first-row vertex only fills the line
// buffer. Any other vertex gets its face product on the shared multiplier and
// then, per normal, a range shift, the squares, the bit-pair square root and
// the three 15-bit quotients of the restoring divider; a zero sum skips to
// the output. A finished normal waits in the output register while rsp_stall
// is high; the unit then holds the next normal until the register drains.
// Reset sets the grid to 128 by 128 and restarts at column 0, row 0. A write
// on the csr_ port also restarts the grid; the user must make it only while
// idle, as the unit itself does not enforce this.
module heightmap_vertex_normals #(
   parameter int MAX_WIDTH  = hvn_pkg::DEF_MAX_WIDTH,
   parameter int COORD_BITS = hvn_pkg::DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [hvn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hvn_pkg::GRID_REG_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hvn_pkg::NORMAL_W-1:0]  rsp_normal_x,
   output logic signed [hvn_pkg::NORMAL_W-1:0]  rsp_normal_y,
   output logic signed [hvn_pkg::NORMAL_W-1:0]  rsp_normal_z,
   output logic [hvn_pkg::VERTEX_IDX_W-1:0]     rsp_vertex_col,
   output logic [hvn_pkg::VERTEX_IDX_W-1:0]     rsp_vertex_row,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_run_last
);
   import hvn_pkg::*;

   cmd_type    cmd;
   status_type status;

   hvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hvn_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .cmd            (cmd),
      .status         (status),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_vertex_col (rsp_vertex_col),
      .rsp_vertex_row (rsp_vertex_row),
      .rsp_degenerate (rsp_degenerate),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

[sv/hvn_checker.sv]
// Port-level assertions for the vertex normal unit, bound to the top level.
module hvn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [hvn_pkg::NORMAL_W-1:0] rsp_normal_x,
   input logic signed [hvn_pkg::NORMAL_W-1:0] rsp_normal_y,
   input logic signed [hvn_pkg::NORMAL_W-1:0] rsp_normal_z,
   input logic                                rsp_degenerate
);
   import hvn_pkg::*;

   localparam logic signed [NORMAL_W-1:0] ONE_POS = 16'sd16384;
   localparam logic signed [NORMAL_W-1:0] ONE_NEG = -16'sd16384;

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate normal is not zero");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_normal_x <= ONE_POS && rsp_normal_x >= ONE_NEG &&
         rsp_normal_y <= ONE_POS && rsp_normal_y >= ONE_NEG &&
         rsp_normal_z <= ONE_POS && rsp_normal_z >= ONE_NEG)
      else $error("normal component beyond unit length");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (.*);
